>>> rtl/tsa_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers for the texture swizzle address unit.
// No dependencies.
package tsa_pkg;

    localparam int COORD_W  = 12;
    localparam int PIX_W    = 32;
    localparam int OFF_W    = 27;
    localparam int LOG2_W   = 4;
    localparam int BPP_W    = 3;
    localparam int SHIFT_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_HEIGHT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd2;

    localparam logic [LOG2_W-1:0] LOG2_WIDTH_RST      = 4'd8;
    localparam logic [LOG2_W-1:0] LOG2_HEIGHT_RST     = 4'd8;
    localparam logic [BPP_W-1:0]  BYTES_PER_PIXEL_RST = 3'd4;

    typedef struct packed {
        logic [LOG2_W-1:0] log2_width;
        logic [LOG2_W-1:0] log2_height;
        logic [BPP_W-1:0]  bytes_per_pixel;
    } cfg_t;

    // Place bit i of v at bit 2*i.
    function automatic logic [2*COORD_W-1:0] spread_bits(input logic [COORD_W-1:0] v);
        logic [2*COORD_W-1:0] r;
        r = '0;
        for (int b = 0; b < COORD_W; b++)
        begin
            r[2*b] = v[b];
        end
        return r;
    endfunction

endpackage

>>> rtl/tsa_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for source pixels and swizzled results.
// Depends on tsa_pkg.
interface tsa_in_if
    import tsa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic [PIX_W-1:0]   pixel_value;

    modport source (output valid, output pixel_col, output pixel_row, output pixel_value,
                    input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input pixel_value,
                    output ready);
endinterface

interface tsa_out_if
    import tsa_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] dest_byte_offset;
    logic [PIX_W-1:0] pixel_out;

    modport source (output valid, output dest_byte_offset, output pixel_out, input ready);
    modport sink   (input valid, input dest_byte_offset, input pixel_out, output ready);
endinterface

>>> rtl/tsa_offset.sv
`timescale 1ns / 1ps
// Z-order byte offset from column, row and surface configuration.
// Depends on tsa_pkg.
module tsa_offset
    import tsa_pkg::*;
#(
    parameter int MAX_LOG2_DIM = 12
)
(
    input  cfg_t               cfg,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    output logic [OFF_W-1:0]   offset
);

    logic [SHIFT_W-1:0]       lw;
    logic [SHIFT_W-1:0]       lh;
    logic [SHIFT_W-1:0]       col_sh;
    logic [COORD_W-1:0]       row_lo;
    logic [COORD_W-1:0]       row_hi;
    logic [COORD_W-1:0]       col_lo;
    logic [COORD_W-1:0]       col_hi;
    logic [OFF_W-1:0]         sy;
    logic [OFF_W-1:0]         sx;
    logic [OFF_W-1:0]         idx;
    logic [OFF_W+BPP_W-1:0]   prod;

    always_comb
    begin
        lw = (SHIFT_W'(cfg.log2_width) > SHIFT_W'(MAX_LOG2_DIM)) ?
             SHIFT_W'(MAX_LOG2_DIM) : SHIFT_W'(cfg.log2_width);
        lh = (SHIFT_W'(cfg.log2_height) > SHIFT_W'(MAX_LOG2_DIM)) ?
             SHIFT_W'(MAX_LOG2_DIM) : SHIFT_W'(cfg.log2_height);
        col_sh = lh + SHIFT_W'(1);

        // wrap row at W, add W*W pixels per wrap
        row_lo = row & ~({COORD_W{1'b1}} << lw);
        row_hi = row >> lw;
        sy = OFF_W'({spread_bits(row_lo), 1'b0}) + (OFF_W'(row_hi) << (lw << 1));

        // wrap column at 2H, add 2*H*H pixels per wrap
        col_lo = col & ~({COORD_W{1'b1}} << col_sh);
        col_hi = col >> col_sh;
        sx = OFF_W'(spread_bits(col_lo)) + (OFF_W'(col_hi) << ((lh << 1) + SHIFT_W'(1)));

        idx  = sx + sy;
        prod = (OFF_W+BPP_W)'(idx) * (OFF_W+BPP_W)'(cfg.bytes_per_pixel);
        offset = prod[OFF_W-1:0];
    end

endmodule

>>> rtl/texture_swizzle_address_unit.sv
`timescale 1ns / 1ps
// Top level of the texture swizzle address unit: config registers and two-stage pipeline.
// Depends on tsa_pkg, tsa_stream_if and tsa_offset.
//
// Usage:
//   src carries one linear-order source pixel per beat (column, row, pixel bytes).
//   dst carries one result per beat: the pixel's byte offset in the Z-order
//   swizzled surface (modulo 2^27) and the pixel bytes unchanged.
//   Configuration (log2 width, log2 height, bytes per pixel) is written through
//   cfg_we / cfg_index / cfg_wdata; the user must write it only while no beat is in
//   flight, as the block itself does not enforce this. Unknown indexes are ignored.
//   Path: a beat accepted on src is captured in the input register, then its offset
//   is computed and captured with the pixel bytes in the result register, which
//   drives dst. Throughput: one beat per cycle while dst is ready, set by the
//   single offset datapath between the two registers.
//   Reset: both stages empty, registers return to 8 / 8 / 4.
//   Stall: when dst is not ready the result holds, the input stage still takes
//   one more beat, and src.ready drops only once both stages are full.
module texture_swizzle_address_unit
    import tsa_pkg::*;
#(
    parameter int MAX_LOG2_DIM = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    tsa_in_if.sink                src,
    tsa_out_if.source             dst
);

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [COORD_W-1:0] s1_col_reg;
    logic [COORD_W-1:0] s1_row_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [OFF_W-1:0]   out_off_reg;
    logic [PIX_W-1:0]   out_pix_reg;
    logic [OFF_W-1:0]   offset;
    logic               advance;
    logic               take;

    assign advance   = !out_valid_reg || dst.ready;
    assign src.ready = !s1_valid_reg || advance;
    assign take      = src.valid && src.ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOG2_WIDTH:      cfg_next.log2_width      = cfg_wdata[LOG2_W-1:0];
                CFG_LOG2_HEIGHT:     cfg_next.log2_height     = cfg_wdata[LOG2_W-1:0];
                CFG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = cfg_wdata[BPP_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.log2_width      <= LOG2_WIDTH_RST;
            cfg_reg.log2_height     <= LOG2_HEIGHT_RST;
            cfg_reg.bytes_per_pixel <= BYTES_PER_PIXEL_RST;
            s1_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_col_reg <= src.pixel_col;
            s1_row_reg <= src.pixel_row;
            s1_pix_reg <= src.pixel_value;
        end
        if (advance && s1_valid_reg)
        begin
            out_off_reg <= offset;
            out_pix_reg <= s1_pix_reg;
        end
    end

    tsa_offset #(
        .MAX_LOG2_DIM (MAX_LOG2_DIM)
    ) u_offset (
        .cfg    (cfg_reg),
        .col    (s1_col_reg),
        .row    (s1_row_reg),
        .offset (offset)
    );

    assign dst.valid            = out_valid_reg;
    assign dst.dest_byte_offset = out_off_reg;
    assign dst.pixel_out        = out_pix_reg;

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> out_valid_reg)
        else $error("pipeline beat lost between stages");

    a_pixel_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> out_pix_reg == $past(s1_pix_reg))
        else $error("pixel bytes changed in flight");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !src.ready |-> s1_valid_reg && out_valid_reg && !dst.ready)
        else $error("input stalled with room in the pipeline");

    a_zero_bpp_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && cfg_reg.bytes_per_pixel == '0 |=> out_off_reg == '0)
        else $error("nonzero offset with zero bytes per pixel");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for texture_swizzle_address_unit: streams source pixels under random
// stalls on both sides, predicts each Z-order byte offset and checks every result beat in order.
// Depends on tsa_pkg, tsa_stream_if and the unit's RTL.
module testbench;
    import tsa_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIM_CAP      = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [OFF_W-1:0] dest_byte_offset;
        logic [PIX_W-1:0] pixel_out;
    } swizzle_result_t;

    class swizzle_offset_tracker;
        localparam int LOG2_CAP     = 12;
        localparam int SHOWN_ERRORS = 10;

        logic [LOG2_W-1:0] log2_width;
        logic [LOG2_W-1:0] log2_height;
        logic [BPP_W-1:0]  bytes_per_pixel;
        swizzle_result_t   awaited[$];
        int                mismatches;

        function new();
            log2_width      = LOG2_WIDTH_RST;
            log2_height     = LOG2_HEIGHT_RST;
            bytes_per_pixel = BYTES_PER_PIXEL_RST;
            mismatches      = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_LOG2_WIDTH:      log2_width      = data[LOG2_W-1:0];
                CFG_LOG2_HEIGHT:     log2_height     = data[LOG2_W-1:0];
                CFG_BYTES_PER_PIXEL: bytes_per_pixel = data[BPP_W-1:0];
                default:             ;
            endcase
        endfunction

        function logic [63:0] interleave(logic [15:0] v);
            logic [63:0] r;
            r = '0;
            for (int b = 0; b < 16; b++)
            begin
                r[2*b] = v[b];
            end
            return r;
        endfunction

        function logic [OFF_W-1:0] predict_offset(logic [COORD_W-1:0] col,
                                                   logic [COORD_W-1:0] row);
            int          lw;
            int          lh;
            logic [63:0] r;
            logic [63:0] c;
            logic [63:0] sy;
            logic [63:0] sx;
            logic [63:0] idx;
            lw  = (log2_width > LOG2_CAP) ? LOG2_CAP : int'(log2_width);
            lh  = (log2_height > LOG2_CAP) ? LOG2_CAP : int'(log2_height);
            r   = 64'(row);
            c   = 64'(col);
            sy  = (interleave(16'(r & ((64'd1 << lw) - 64'd1))) << 1) + ((r >> lw) << (2 * lw));
            sx  = interleave(16'(c & ((64'd1 << (lh + 1)) - 64'd1)))
                  + ((c >> (lh + 1)) << (2 * lh + 1));
            idx = 64'(OFF_W'(sx + sy));
            return OFF_W'(idx * 64'(bytes_per_pixel));
        endfunction

        function void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
                $display("%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        endfunction

        function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                 logic [PIX_W-1:0] value);
            swizzle_result_t res;
            res.dest_byte_offset = predict_offset(col, row);
            res.pixel_out        = value;
            awaited.push_back(res);
        endfunction

        function void check_result(logic [OFF_W-1:0] offset, logic [PIX_W-1:0] pixel);
            swizzle_result_t want;
            if (awaited.size() == 0)
            begin
                note_mismatch("result beat with nothing awaited, offset", '0, 64'(offset));
                return;
            end
            want = awaited.pop_front();
            if (offset !== want.dest_byte_offset)
                note_mismatch("dest_byte_offset", 64'(want.dest_byte_offset), 64'(offset));
            if (pixel !== want.pixel_out)
                note_mismatch("pixel_out", 64'(want.pixel_out), 64'(pixel));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    bit                    calm;
    int unsigned           cycle_count;
    swizzle_offset_tracker tracker;

    tsa_in_if  src();
    tsa_out_if dst();

    texture_swizzle_address_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .src       (src),
        .dst       (dst)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 25);
    endfunction

    function automatic int cap_log2(int v);
        return (v > DIM_CAP) ? DIM_CAP : v;
    endfunction

    // In-surface most of the time, otherwise near the wrap point, anywhere, or at 0 or the top value.
    function automatic logic [COORD_W-1:0] pick_coord(int span, int wrap);
        int mode;
        int v;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            v = $urandom_range(0, (1 << span) - 1);
        else if (mode < 8)
            v = (1 << wrap) + $urandom_range(0, 3) - 2;
        else if (mode < 9)
            v = $urandom_range(0, (1 << COORD_W) - 1);
        else
            v = $urandom_range(0, 1) ? (1 << COORD_W) - 1 : 0;
        if (v < 0)
            v = 0;
        if (v > (1 << COORD_W) - 1)
            v = (1 << COORD_W) - 1;
        return COORD_W'(v);
    endfunction

    always @(posedge clk)
    begin
        if (src.valid && src.ready)
            tracker.note_pixel(src.pixel_col, src.pixel_row, src.pixel_value);
        if (dst.valid && dst.ready)
            tracker.check_result(dst.dest_byte_offset, dst.pixel_out);
    end

    always @(negedge clk)
    begin
        dst.ready <= rst_n && !take_break();
    end

    task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                              logic [PIX_W-1:0] value);
        while (take_break())
        begin
            @(negedge clk);
            src.valid <= 1'b0;
        end
        @(negedge clk);
        src.valid       <= 1'b1;
        src.pixel_col   <= col;
        src.pixel_row   <= row;
        src.pixel_value <= value;
        @(posedge clk);
        while (!src.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        src.valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        tracker.write_register(index, data);
    endtask

    task automatic configure(logic [LOG2_W-1:0] lw, logic [LOG2_W-1:0] lh,
                             logic [BPP_W-1:0] bpp);
        drain_results();
        write_register(CFG_LOG2_WIDTH, CFG_DATA_W'(lw));
        write_register(CFG_LOG2_HEIGHT, CFG_DATA_W'(lh));
        write_register(CFG_BYTES_PER_PIXEL, CFG_DATA_W'(bpp));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int lw;
        int lh;
        int bpp;
        tracker         = new();
        calm            = 1'b0;
        cycle_count     = 0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_LOG2_WIDTH;
        cfg_wdata       = '0;
        src.valid       = 1'b0;
        src.pixel_col   = '0;
        src.pixel_row   = '0;
        src.pixel_value = '0;
        dst.ready       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset geometry: 256 x 256, four bytes per pixel
        send_pixel(12'd0, 12'd0, 32'h0000_0000);
        send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
        send_pixel(12'd255, 12'd255, 32'h0123_4567);
        send_pixel(12'd511, 12'd256, 32'h89AB_CDEF);
        send_pixel(12'd512, 12'd0, 32'h5555_AAAA);
        send_pixel(12'd0, 12'd256, 32'hAAAA_5555);

        // log2 above the cap saturates, zero bytes per pixel
        configure(4'd15, 4'd13, 3'd0);
        write_register(CFG_UNUSED_INDEX, '1);
        @(negedge clk);
        cfg_we <= 1'b0;
        send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
        send_pixel(12'd4095, 12'd0, 32'hA5A5_A5A5);
        send_pixel(12'd0, 12'd4095, 32'h5A5A_5A5A);

        // one-pixel surface, every row wraps; oversized pixel scale
        configure(4'd0, 4'd0, 3'd7);
        send_pixel(12'd1, 12'd1, 32'h0000_00FF);
        send_pixel(12'd4095, 12'd4095, 32'hFF00_0000);
        send_pixel(12'd2, 12'd3, 32'h1234_5678);

        // largest surface
        configure(4'd12, 4'd12, 3'd5);
        send_pixel(12'd4095, 12'd4095, 32'hDEAD_BEEF);
        send_pixel(12'd2048, 12'd4095, 32'h0F0F_0F0F);
        send_pixel(12'd0, 12'd0, 32'hF0F0_F0F0);

        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase == 0)
            begin
                lw  = 0;
                lh  = 0;
                bpp = 1;
            end
            else if (phase == 1)
            begin
                lw  = 12;
                lh  = 12;
                bpp = 4;
            end
            else
            begin
                lw  = $urandom_range(0, 15);
                lh  = $urandom_range(0, 15);
                bpp = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 7);
            end
            configure(LOG2_W'(lw), LOG2_W'(lh), BPP_W'(bpp));
            calm = (phase == 4);
            repeat (50)
                send_pixel(pick_coord(cap_log2(lw), cap_log2(lh) + 1),
                           pick_coord(cap_log2(lh), cap_log2(lw)),
                           PIX_W'($urandom));
        end
        calm = 1'b0;
        drain_results();

        if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            if (tracker.awaited.size() != 0)
                $display("%0d expected results never arrived", tracker.awaited.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> texture_swizzle_address_unit.f
rtl/tsa_pkg.sv
rtl/tsa_stream_if.sv
rtl/tsa_offset.sv
rtl/texture_swizzle_address_unit.sv
tb/sv/testbench.sv
